@@ src/ifle_pkg.sv @@
// ============================================================================
// ifle_pkg - shared types and constants of the intrusive free list engine
// Request and response payloads, command and status codes, link coding and
// saturating count helpers.
// ============================================================================
package ifle_pkg;

    // Pool geometry
    localparam int POOL_WORDS = 4096;
    localparam int POOL_AW    = $clog2(POOL_WORDS);
    localparam int CNT_W      = $clog2(POOL_WORDS + 1);

    // Field widths fixed by the request and response formats
    localparam int ADDR_W = 12;
    localparam int LINK_W = ADDR_W + 1;
    localparam int AMT_W  = 13;
    localparam int SUM_W  = ((CNT_W > AMT_W) ? CNT_W : AMT_W) + 1;

    // Address space limit for carving, and the null link
    localparam logic [AMT_W-1:0]  ADDR_SPACE = AMT_W'(1 << ADDR_W);
    localparam logic [LINK_W-1:0] LINK_NULL  = LINK_W'(1 << ADDR_W);

    // Command codes
    localparam logic [2:0] CMD_PUSH       = 3'd0;
    localparam logic [2:0] CMD_POP        = 3'd1;
    localparam logic [2:0] CMD_PUSH_RANGE = 3'd2;
    localparam logic [2:0] CMD_POP_RANGE  = 3'd3;
    localparam logic [2:0] CMD_CARVE      = 3'd4;

    // Status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NULL_EMPTY = 2'd1;
    localparam logic [1:0] ST_BAD_CARVE = 2'd2;

    typedef struct packed {
        logic [2:0]        cmd;
        logic [ADDR_W-1:0] addr;
        logic              addr_null;
        logic [AMT_W-1:0]  end_addr;
        logic [AMT_W-1:0]  amount;
        logic [AMT_W-1:0]  block_size;
    } req_t;

    typedef struct packed {
        logic [1:0]        status;
        logic [ADDR_W-1:0] first_addr;
        logic [ADDR_W-1:0] last_addr;
        logic [AMT_W-1:0]  moved;
        logic [AMT_W-1:0]  free_count;
    } rsp_t;

    // Link store index of a link or address value
    function automatic logic [POOL_AW-1:0] slot(input logic [LINK_W-1:0] v);
        return POOL_AW'(v % POOL_WORDS);
    endfunction

    // Add with saturation at the pool size
    function automatic logic [CNT_W-1:0] cnt_add(input logic [CNT_W-1:0] c,
                                                 input logic [AMT_W-1:0] n);
        logic [SUM_W-1:0] s;
        s = SUM_W'(c) + SUM_W'(n);
        return (s > SUM_W'(POOL_WORDS)) ? CNT_W'(POOL_WORDS) : CNT_W'(s);
    endfunction

    // Subtract with saturation at zero
    function automatic logic [CNT_W-1:0] cnt_sub(input logic [CNT_W-1:0] c,
                                                 input logic [AMT_W-1:0] n);
        logic [SUM_W-1:0] cw;
        logic [SUM_W-1:0] nw;
        cw = SUM_W'(c);
        nw = SUM_W'(n);
        return (nw > cw) ? '0 : CNT_W'(cw - nw);
    endfunction

endpackage

@@ src/ifle_if.sv @@
// ============================================================================
// ifle_if - request and response channels of the free list engine
// Valid/ready channels; a request moves at a clock edge with both high.
// ============================================================================
interface ifle_req_if;
    logic          valid;
    logic          ready;
    ifle_pkg::req_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface ifle_rsp_if;
    logic          valid;
    logic          ready;
    ifle_pkg::rsp_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ src/intrusive_free_list_engine_unit.sv @@
// ============================================================================
// intrusive_free_list_engine_unit - LIFO free list allocator engine
// Keeps a linked free list whose links live in a one-port-read,
// one-port-write synchronous link memory; head and count in registers.
// ============================================================================
// Usage:
//   req (sink) carries one command per request: push, pop, push range,
//   pop range or carve. rsp (source) returns exactly one response per
//   request, in order: status, first/last object, objects moved and the
//   free count after the command.
//   Commands run one at a time; the response register loads as the engine
//   returns to idle. Push, push range, empty pops, rejected or unknown
//   commands do no link memory read; a pop does one link memory read, a
//   pop range one link read per object walked, and a carve one link write
//   per block. The engine uses the link memory port for one access a cycle.
//   A finished response waits in the output register; req is taken again
//   as soon as the engine is back in idle, so the next command runs while
//   the receiver stalls. A second response waits in the result holding
//   registers until the output register frees.
//   Reset empties the list (null head, count zero) and drops any response.
//   The link memory is not cleared; its entries hold garbage until written.
// ============================================================================
module intrusive_free_list_engine_unit
(
    input  logic           clk,
    input  logic           rst_n,
    ifle_req_if.sink       req,
    ifle_rsp_if.source     rsp
);
    import ifle_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_POP,
        S_WALK,
        S_CARVE,
        S_DONE
    } state_t;

    state_t               state_reg, state_next;
    logic [LINK_W-1:0]    head_reg, head_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [ADDR_W-1:0]    tail_reg, tail_next;
    logic [AMT_W-1:0]     n_reg, n_next;
    logic [AMT_W-1:0]     amount_reg, amount_next;
    logic [AMT_W:0]       cur_reg, cur_next;
    logic [AMT_W-1:0]     lim_reg, lim_next;
    logic [AMT_W-1:0]     bsize_reg, bsize_next;
    logic [ADDR_W-1:0]    start_reg, start_next;
    rsp_t                 res_reg, res_next;
    logic                 out_valid_reg, out_valid_next;
    rsp_t                 out_data_reg, out_data_next;

    // Link memory ports
    logic [LINK_W-1:0]    link_mem [POOL_WORDS];
    logic                 mem_we;
    logic [POOL_AW-1:0]   mem_waddr;
    logic [LINK_W-1:0]    mem_wdata;
    logic                 mem_re;
    logic [POOL_AW-1:0]   mem_raddr;
    logic [LINK_W-1:0]    mem_rdata_reg;

    logic                 req_fire;
    logic                 out_free;
    logic [AMT_W-1:0]     lim;
    logic [AMT_W:0]       carve_cur;
    logic [LINK_W-1:0]    nx;

    assign req.ready = (state_reg == S_IDLE);
    assign req_fire  = req.valid && req.ready;
    assign rsp.valid = out_valid_reg;
    assign rsp.data  = out_data_reg;
    assign out_free  = !out_valid_reg || rsp.ready;

    // Clamp the carve end to the address space
    assign lim       = (req.data.end_addr > ADDR_SPACE) ? ADDR_SPACE : req.data.end_addr;
    assign carve_cur = (AMT_W + 1)'(req.data.addr) + (AMT_W + 1)'(req.data.block_size);
    assign nx        = mem_rdata_reg;

    always_comb
    begin
        state_next     = state_reg;
        head_next      = head_reg;
        count_next     = count_reg;
        tail_next      = tail_reg;
        n_next         = n_reg;
        amount_next    = amount_reg;
        cur_next       = cur_reg;
        lim_next       = lim_reg;
        bsize_next     = bsize_reg;
        start_next     = start_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        mem_we         = 1'b0;
        mem_waddr      = '0;
        mem_wdata      = '0;
        mem_re         = 1'b0;
        mem_raddr      = '0;

        // Drop the response once taken
        if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_fire)
                begin
                    res_next   = '0;
                    state_next = S_DONE;
                    case (req.data.cmd)
                        CMD_PUSH:
                        begin
                            if (req.data.addr_null)
                            begin
                                res_next.status = ST_NULL_EMPTY;
                            end
                            else
                            begin
                                mem_we         = 1'b1;
                                mem_waddr      = slot(LINK_W'(req.data.addr));
                                mem_wdata      = head_reg;
                                head_next      = LINK_W'(req.data.addr);
                                count_next     = cnt_add(count_reg, AMT_W'(1));
                                res_next.moved = AMT_W'(1);
                            end
                        end
                        CMD_POP:
                        begin
                            if (head_reg[ADDR_W])
                            begin
                                res_next.status = ST_NULL_EMPTY;
                            end
                            else
                            begin
                                mem_re              = 1'b1;
                                mem_raddr           = slot(head_reg);
                                res_next.first_addr = head_reg[ADDR_W-1:0];
                                state_next          = S_POP;
                            end
                        end
                        CMD_PUSH_RANGE:
                        begin
                            mem_we         = 1'b1;
                            mem_waddr      = slot(req.data.end_addr);
                            mem_wdata      = head_reg;
                            head_next      = LINK_W'(req.data.addr);
                            count_next     = cnt_add(count_reg, req.data.amount);
                            res_next.moved = req.data.amount;
                        end
                        CMD_POP_RANGE:
                        begin
                            // An empty list answers ok with nothing moved
                            if (!head_reg[ADDR_W])
                            begin
                                mem_re              = 1'b1;
                                mem_raddr           = slot(head_reg);
                                res_next.first_addr = head_reg[ADDR_W-1:0];
                                tail_next           = head_reg[ADDR_W-1:0];
                                n_next              = AMT_W'(1);
                                amount_next         = req.data.amount;
                                state_next          = S_WALK;
                            end
                        end
                        CMD_CARVE:
                        begin
                            if ((AMT_W'(req.data.addr) >= lim) ||
                                (req.data.block_size == '0))
                            begin
                                res_next.status = ST_BAD_CARVE;
                            end
                            else
                            begin
                                tail_next  = req.data.addr;
                                start_next = req.data.addr;
                                cur_next   = carve_cur;
                                lim_next   = lim;
                                bsize_next = req.data.block_size;
                                n_next     = AMT_W'(1);
                                state_next = S_CARVE;
                            end
                        end
                        default:
                        begin
                            // Unknown command: answer ok from current state
                        end
                    endcase
                end
            end
            S_POP:
            begin
                head_next      = nx;
                count_next     = cnt_sub(count_reg, AMT_W'(1));
                res_next.moved = AMT_W'(1);
                state_next     = S_DONE;
            end
            S_WALK:
            begin
                // Stop at the requested count or at the list end
                if ((n_reg >= amount_reg) || nx[ADDR_W])
                begin
                    head_next          = nx;
                    mem_we             = 1'b1;
                    mem_waddr          = slot(LINK_W'(tail_reg));
                    mem_wdata          = LINK_NULL;
                    count_next         = cnt_sub(count_reg, n_reg);
                    res_next.last_addr = tail_reg;
                    res_next.moved     = n_reg;
                    state_next         = S_DONE;
                end
                else
                begin
                    mem_re    = 1'b1;
                    mem_raddr = slot(nx);
                    tail_next = nx[ADDR_W-1:0];
                    n_next    = n_reg + AMT_W'(1);
                end
            end
            S_CARVE:
            begin
                mem_we    = 1'b1;
                mem_waddr = slot(LINK_W'(tail_reg));
                if (cur_reg < (AMT_W + 1)'(lim_reg))
                begin
                    // Link this block to the next one and advance
                    mem_wdata = LINK_W'(cur_reg[ADDR_W-1:0]);
                    tail_next = cur_reg[ADDR_W-1:0];
                    cur_next  = cur_reg + (AMT_W + 1)'(bsize_reg);
                    n_next    = n_reg + AMT_W'(1);
                end
                else
                begin
                    // Last block takes the old head; the run becomes the list
                    mem_wdata      = head_reg;
                    head_next      = LINK_W'(start_reg);
                    count_next     = cnt_add(count_reg, n_reg);
                    res_next.moved = n_reg;
                    state_next     = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next            = 1'b1;
                    out_data_next             = res_reg;
                    out_data_next.free_count  = AMT_W'(count_reg);
                    state_next                = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= LINK_NULL;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Working and payload registers carry no reset
    always_ff @(posedge clk)
    begin
        tail_reg     <= tail_next;
        n_reg        <= n_next;
        amount_reg   <= amount_next;
        cur_reg      <= cur_next;
        lim_reg      <= lim_next;
        bsize_reg    <= bsize_next;
        start_reg    <= start_next;
        res_reg      <= res_next;
        out_data_reg <= out_data_next;
    end

    // Link memory: one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            link_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            mem_rdata_reg <= link_mem[mem_raddr];
        end
    end

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(POOL_WORDS))
        else $error("free count above pool size");

    a_mem_one_access: assert property (@(posedge clk) disable iff (!rst_n)
        !(mem_we && mem_re))
        else $error("link memory read and write in the same cycle");

    a_leave_idle: assert property (@(posedge clk) disable iff (!rst_n)
        req_fire |=> (state_reg != S_IDLE))
        else $error("accepted request did not start");

    a_rsp_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_DONE))
        else $error("response loaded outside completion");

    a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WALK) |-> ((n_reg <= amount_reg) || (n_reg == AMT_W'(1))))
        else $error("pop range walked past requested count");
`endif

endmodule

@@ tb/tb_intrusive_free_list_engine_unit.sv @@
// ============================================================================
// tb_intrusive_free_list_engine_unit - free list engine testbench
// Drives push, pop, range and carve requests through the valid/ready request
// channel and checks every response against a cycle-free model of the list
// that keeps its own link table, head pointer and saturating free count.
// ============================================================================
import ifle_pkg::*;

class free_list_shadow;
    logic [LINK_W-1:0] links [POOL_WORDS];
    logic [LINK_W-1:0] head;
    int unsigned       count;
    rsp_t              expected_q [$];
    int unsigned       errors;
    int unsigned       checked;

    function new();
        head    = LINK_NULL;
        count   = 0;
        errors  = 0;
        checked = 0;
    endfunction

    function void grow(input int unsigned n);
        count = (count + n > POOL_WORDS) ? POOL_WORDS : count + n;
    endfunction

    function void shrink(input int unsigned n);
        count = (n > count) ? 0 : count - n;
    endfunction

    // Apply one accepted request to the list and queue its response
    function rsp_t note_request(input req_t r);
        rsp_t              e;
        int unsigned       tail;
        int unsigned       cur;
        int unsigned       lim;
        int unsigned       n;
        int unsigned       i;
        logic [LINK_W-1:0] nx;
        e = '0;
        case (r.cmd)
            CMD_PUSH:
            begin
                if (r.addr_null)
                    e.status = ST_NULL_EMPTY;
                else
                begin
                    links[r.addr] = head;
                    head          = {1'b0, r.addr};
                    grow(1);
                    e.moved = AMT_W'(1);
                end
            end
            CMD_POP:
            begin
                if (head[ADDR_W])
                    e.status = ST_NULL_EMPTY;
                else
                begin
                    e.first_addr = head[ADDR_W-1:0];
                    head         = links[e.first_addr];
                    shrink(1);
                    e.moved = AMT_W'(1);
                end
            end
            CMD_PUSH_RANGE:
            begin
                links[int'(r.end_addr) % POOL_WORDS] = head;
                head = {1'b0, r.addr};
                grow(r.amount);
                e.moved = r.amount;
            end
            CMD_POP_RANGE:
            begin
                if (!head[ADDR_W])
                begin
                    tail = head[ADDR_W-1:0];
                    n    = 1;
                    e.first_addr = ADDR_W'(tail);
                    for (i = 1; i < r.amount; i++)
                    begin
                        nx = links[tail];
                        if (nx[ADDR_W])
                            break;
                        tail = nx[ADDR_W-1:0];
                        n++;
                    end
                    head        = links[tail];
                    links[tail] = LINK_NULL;
                    shrink(n);
                    e.last_addr = ADDR_W'(tail);
                    e.moved     = AMT_W'(n);
                end
            end
            CMD_CARVE:
            begin
                lim = (r.end_addr > ADDR_SPACE) ? ADDR_SPACE : r.end_addr;
                if (r.addr >= lim || r.block_size == 0)
                    e.status = ST_BAD_CARVE;
                else
                begin
                    tail = r.addr;
                    cur  = r.addr + r.block_size;
                    n    = 1;
                    while (cur < lim)
                    begin
                        links[tail] = LINK_W'(cur);
                        tail = cur;
                        cur  = cur + r.block_size;
                        n++;
                    end
                    links[tail] = head;
                    head = {1'b0, r.addr};
                    grow(n);
                    e.moved = AMT_W'(n);
                end
            end
            default:
            begin
            end
        endcase
        e.free_count = AMT_W'(count);
        expected_q.push_back(e);
        return e;
    endfunction

    function void compare_field(input string name, input logic [AMT_W-1:0] want,
                                input logic [AMT_W-1:0] got);
        if (got !== want)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endfunction

    function void check_response(input rsp_t got);
        rsp_t want;
        if (expected_q.size() == 0)
        begin
            errors++;
            $display("%0t: response with none expected, actual status %0d moved %0d",
                     $time, got.status, got.moved);
            return;
        end
        want = expected_q.pop_front();
        checked++;
        compare_field("status", AMT_W'(want.status), AMT_W'(got.status));
        compare_field("first_addr", AMT_W'(want.first_addr), AMT_W'(got.first_addr));
        compare_field("last_addr", AMT_W'(want.last_addr), AMT_W'(got.last_addr));
        compare_field("moved", want.moved, got.moved);
        compare_field("free_count", want.free_count, got.free_count);
    endfunction
endclass

module tb_intrusive_free_list_engine_unit;

    localparam int unsigned RANDOM_REQUESTS = 1425;
    localparam int unsigned HOLD_CYCLES     = 400;
    localparam int unsigned CYCLE_LIMIT     = 1_000_000;
    localparam int unsigned DRAIN_CYCLES    = 40;

    typedef struct {
        logic [ADDR_W-1:0] first;
        logic [ADDR_W-1:0] last;
        logic [AMT_W-1:0]  count;
    } popped_run_t;

    logic clk;
    logic rst_n;

    ifle_req_if req_ch ();
    ifle_rsp_if rsp_ch ();

    intrusive_free_list_engine_unit dut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    free_list_shadow shadow;

    // Objects and runs handed out by pops, kept so that later pushes and
    // range pushes can return them the way a real allocator user would
    logic [ADDR_W-1:0] spare_objs [$];
    popped_run_t       spare_runs [$];

    int unsigned cmd_seen [8];
    int unsigned cycle_count;
    bit          calm;       // both sides stop idling while set
    bit          hold_off;   // ask the receiver for one long stall

    always #6 clk = ~clk;

    // Build one request from its fields
    function automatic req_t request(input logic [2:0] cmd, input int unsigned addr,
                                     input bit anull, input int unsigned end_addr,
                                     input int unsigned amount, input int unsigned bsize);
        req_t r;
        r.cmd        = cmd;
        r.addr       = ADDR_W'(addr);
        r.addr_null  = anull;
        r.end_addr   = AMT_W'(end_addr);
        r.amount     = AMT_W'(amount);
        r.block_size = AMT_W'(bsize);
        return r;
    endfunction

    // Mostly allocator-like traffic: pushes return popped objects, range
    // pushes return popped runs, carves stay small. The rest is noise.
    function automatic req_t random_request();
        req_t        r;
        popped_run_t run;
        int unsigned pick;
        int unsigned shape;
        r = request(CMD_PUSH, $urandom_range(0, 4095), ($urandom_range(0, 99) < 5),
                    $urandom_range(0, 4096), $urandom_range(0, 4096),
                    $urandom_range(0, 4096));
        pick = $urandom_range(0, 99);
        if (pick < 3)
            r.cmd = 3'($urandom_range(5, 7));
        else if (pick < 28)
        begin
            if (spare_objs.size() != 0 && $urandom_range(0, 3) != 0)
                r.addr = spare_objs.pop_front();
        end
        else if (pick < 50)
            r.cmd = CMD_POP;
        else if (pick < 66)
        begin
            r.cmd    = CMD_POP_RANGE;
            r.amount = ($urandom_range(0, 99) < 4) ? AMT_W'($urandom_range(0, 4096))
                                                   : AMT_W'($urandom_range(0, 12));
        end
        else if (pick < 80)
        begin
            r.cmd = CMD_PUSH_RANGE;
            if (spare_runs.size() != 0 && $urandom_range(0, 4) != 0)
            begin
                run        = spare_runs.pop_front();
                r.addr     = run.first;
                r.end_addr = AMT_W'(run.last);
                r.amount   = run.count;
            end
            else
                r.amount = AMT_W'($urandom_range(0, 16));
        end
        else
        begin
            r.cmd        = CMD_CARVE;
            shape        = $urandom_range(0, 99);
            r.block_size = AMT_W'($urandom_range(1, 64));
            if (shape < 6)
                r.block_size = '0;
            else if (shape < 12)
                r.end_addr = AMT_W'($urandom_range(0, r.addr));
            else if (shape < 17)
            begin
                // end may run past the address space; the engine clips it
                r.end_addr   = AMT_W'($urandom_range(0, 8191));
                r.block_size = AMT_W'($urandom_range(1, 4096));
            end
            else
                r.end_addr = AMT_W'(r.addr + r.block_size * $urandom_range(1, 16));
        end
        return r;
    endfunction

    // Offer one request, hold it until the engine takes it, then record it
    task automatic issue(input req_t r);
        rsp_t e;
        @(negedge clk);
        while (!calm && $urandom_range(0, 99) < 8)
        begin
            req_ch.valid <= 1'b0;
            @(negedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.data  <= r;
        @(posedge clk);
        while (req_ch.ready !== 1'b1)
            @(posedge clk);
        e = shadow.note_request(r);
        cmd_seen[r.cmd]++;
        if (r.cmd == CMD_POP && e.status == ST_OK && spare_objs.size() < 64)
            spare_objs.push_back(e.first_addr);
        if (r.cmd == CMD_POP_RANGE && e.moved != 0 && spare_runs.size() < 64)
            spare_runs.push_back('{e.first_addr, e.last_addr, e.moved});
    endtask

    // Response side: random stalls, plus one long hold-off on request so
    // that the engine's output and holding registers fill and req stalls
    initial
    begin
        int unsigned held;
        rsp_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (hold_off)
            begin
                hold_off = 1'b0;
                rsp_ch.ready <= 1'b0;
                for (held = 0; held < HOLD_CYCLES; held++)
                    @(negedge clk);
            end
            rsp_ch.ready <= calm || ($urandom_range(0, 99) >= 8);
        end
    end

    // Sample responses at the rising edge, before the engine updates
    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
            shadow.check_response(rsp_ch.data);
    end

    // Watchdog: a stuck handshake or a lost response ends here
    initial
    begin
        for (cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++)
            @(posedge clk);
        $display("FAILURE");
        $finish;
    end

    initial
    begin
        req_t        r;
        int unsigned idx;
        int unsigned issued;
        shadow       = new();
        clk          = 1'b0;
        rst_n        = 1'b0;
        calm         = 1'b0;
        hold_off     = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.data  = '0;
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;

        // Directed part. Until the full-pool carve every pop reads only links
        // written earlier; that carve then writes every link, so nothing later
        // can touch link memory that was never written.
        issue(request(CMD_POP, 0, 0, 0, 0, 0));                   // pop on empty list
        issue(request(CMD_POP_RANGE, 0, 0, 0, 5, 0));             // run pop on empty list
        issue(request(CMD_PUSH, 4095, 1, 0, 0, 0));               // null push
        issue(request(CMD_PUSH, 0, 0, 0, 0, 0));
        issue(request(CMD_PUSH, 4095, 0, 0, 0, 0));
        issue(request(CMD_POP, 0, 0, 0, 0, 0));                   // link left in place
        issue(request(CMD_CARVE, 100, 0, 100, 0, 4));             // empty carve window
        issue(request(CMD_CARVE, 0, 0, 64, 0, 0));                // zero stride
        issue(request(CMD_CARVE, 16, 0, 64, 0, 16));
        issue(request(CMD_POP_RANGE, 0, 0, 0, 0, 0));             // amount 0 pops one
        issue(request(CMD_POP_RANGE, 0, 0, 0, 1, 0));             // amount 1 pops one
        issue(request(CMD_POP_RANGE, 0, 0, 0, 4096, 0));          // stops at list end
        issue(request(CMD_PUSH_RANGE, 16, 0, 16, 0, 0));          // zero count range
        issue(request(CMD_CARVE, 4000, 0, 8191, 0, 1000));        // end clipped to 4096
        issue(request(CMD_CARVE, 0, 0, 4096, 0, 1));              // whole pool, count saturates
        issue(request(CMD_PUSH, 5, 0, 0, 0, 0));
        issue(request(CMD_PUSH_RANGE, 7, 0, 7, 4096, 0));
        issue(request(CMD_PUSH_RANGE, 9, 0, 4096, 3, 0));         // end wraps onto link 0
        issue(request(CMD_POP_RANGE, 0, 0, 0, 4096, 0));          // count floors at zero
        issue(request(CMD_POP, 0, 0, 0, 0, 0));
        issue(request(CMD_CARVE, 0, 0, 4096, 0, 4096));           // one block of full size
        issue(request(3'd5, 4095, 1, 8191, 8191, 8191));          // unknown commands
        issue(request(3'd6, 4095, 1, 8191, 8191, 8191));
        issue(request(3'd7, 0, 0, 0, 0, 0));

        // Random part; unknown commands do not count toward the total
        idx    = 0;
        issued = 0;
        while (issued < RANDOM_REQUESTS)
        begin
            calm = (idx >= 700 && idx < 900);
            if (idx == 300)
                hold_off = 1'b1;
            r = random_request();
            issue(r);
            if (r.cmd <= CMD_CARVE)
                issued++;
            idx++;
        end
        @(negedge clk);
        req_ch.valid <= 1'b0;

        // Drain, then give a late or extra response time to show up
        while (shadow.expected_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Ran push %0d, pop %0d, push range %0d, pop range %0d, carve %0d, unknown %0d",
                 cmd_seen[CMD_PUSH], cmd_seen[CMD_POP], cmd_seen[CMD_PUSH_RANGE],
                 cmd_seen[CMD_POP_RANGE], cmd_seen[CMD_CARVE],
                 cmd_seen[5] + cmd_seen[6] + cmd_seen[7]);
        $display("%0d responses checked with %0d errors, one %0d-cycle receiver stall",
                 shadow.checked, shadow.errors, HOLD_CYCLES);
        if (shadow.errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

@@ filelist.f @@
src/ifle_pkg.sv
src/ifle_if.sv
src/intrusive_free_list_engine_unit.sv
tb/tb_intrusive_free_list_engine_unit.sv
